// File: rtl/mpq_pkg.sv
// Package for the max priority queue: widths, codes, payload and control types.
package mpq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int OCC_W        = 5;

    typedef enum logic
    {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed
    {
        action_t                    action;
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

    typedef struct packed
    {
        logic signed [VALUE_W-1:0]  out_value;
        status_t                    status;
        logic [OCC_W-1:0]           occupancy;
    } res_t;

    typedef struct packed
    {
        logic insert;
        logic remove;
    } op_ctrl_t;

endpackage

// File: rtl/max_priority_queue.sv
// Top level of the max priority queue: command register, occupancy and result register.
//
//   channel   signals                 direction  transfer when
//   command   start, busy, command    in         start && !busy at a rising edge
//   result    done, result            out        done high, taken at the next edge
//
// One command is taken every cycle while busy is low. A command is registered at
// the edge that takes it, works on the entry array through the next cycle, and
// its result is strobed on done for one cycle starting at the following edge.
// The entry array is a row of registers updated in a single compare-and-shift
// pass, which sets the one-per-cycle rate.
// Reset clears the occupancy and pending strobes; entry contents stay undefined
// until written. busy is high while reset is asserted and until the first rising edge after release.
// The receiver cannot stall, so the result register never holds off a command.
module max_priority_queue
    import mpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  cmd_t  command,
    output logic  done,
    output res_t  result
);

    logic                      busy_reg;
    logic                      cmd_valid_reg;
    cmd_t                      cmd_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      done_reg;
    res_t                      result_reg;
    res_t                      result_next;
    op_ctrl_t                  ctrl;
    logic                      full;
    logic                      empty;
    logic signed [VALUE_W-1:0] top_value;

    // Hold off commands while reset is asserted and until the first rising edge after release.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;

    // Command register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= start && !busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            cmd_reg <= command;
        end
    end

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    assign ctrl.insert = cmd_valid_reg && (cmd_reg.action == ACT_INSERT) && !full;
    assign ctrl.remove = cmd_valid_reg && (cmd_reg.action == ACT_REMOVE) && !empty;

    mpq_entry_array #(
        .CAPACITY (CAPACITY)
    ) u_entries (
        .clk       (clk),
        .insert    (ctrl.insert),
        .value     (cmd_reg.value),
        .count     (count_reg),
        .top_value (top_value)
    );

    // Decide status and the new occupancy for the registered command.
    always_comb
    begin
        count_next            = count_reg;
        result_next.out_value = '0;
        if (ctrl.insert)
        begin
            count_next         = count_reg + CNT_W'(1);
            result_next.status = ST_INSERTED;
        end
        else if (ctrl.remove)
        begin
            count_next            = count_reg - CNT_W'(1);
            result_next.out_value = top_value;
            result_next.status    = ST_REMOVED;
        end
        else if (cmd_reg.action == ACT_INSERT)
        begin
            result_next.status = ST_FULL;
        end
        else
        begin
            result_next.status = ST_UNDERFLOW;
        end
        // Occupancy reports the low bits of the count.
        result_next.occupancy = OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cmd_valid_reg)
            begin
                count_reg <= count_next;
            end
            done_reg <= cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every transferred command yields its result strobe on done.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("command transfer without result strobe");

    // Only a successful remove carries a value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_REMOVED)) |-> (result.out_value == '0))
        else $error("nonzero value on a result that is not a remove");

    // Occupancy never exceeds capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // Underflow only happens with an empty store, and it stays empty.
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_UNDERFLOW)) |-> (count_reg == '0))
        else $error("underflow reported with entries held");

    // A remove lowers the count by one.
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.remove |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("remove did not decrement count");

endmodule

// File: rtl/mpq_entry_array.sv
// Sorted entry register array with parallel compare-and-shift insertion.
module mpq_entry_array
    import mpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int IDX_W   = $clog2(CAPACITY)
)
(
    input  logic                       clk,
    input  logic                       insert,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic [CNT_W-1:0]           count,
    output logic signed [VALUE_W-1:0]  top_value
);

    logic signed [VALUE_W-1:0] entry_reg  [CAPACITY];
    logic signed [VALUE_W-1:0] entry_next [CAPACITY];
    logic [CAPACITY-1:0]       keep;
    logic [CNT_W-1:0]          top_pos;

    // Entries at or below the new value stay put; they form a prefix.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            keep[i] = (CNT_W'(i) < count) && (entry_reg[i] <= value);
        end
    end

    // Insert the value just above the kept prefix, shift the rest up one.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (keep[i])
            begin
                entry_next[i] = entry_reg[i];
            end
            else if (i == 0)
            begin
                entry_next[i] = value;
            end
            else if (keep[i-1])
            begin
                entry_next[i] = value;
            end
            else
            begin
                entry_next[i] = entry_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                entry_reg[i] <= entry_next[i];
            end
        end
    end

    // Largest value sits at the highest occupied slot.
    assign top_pos   = count - CNT_W'(1);
    assign top_value = entry_reg[top_pos[IDX_W-1:0]];

endmodule

// File: bench/tb.sv
// Self-checking testbench for the max priority queue: directed cases, fill/drain rounds, random mix.
module tb;
    import mpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Generous watchdog limit, far above what about 700 transfers with their idle
    // gaps and result latency need.
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_TAIL  = 4;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t command;
    logic done;
    res_t result;

    // Shadow copy of the queue contents, ascending, and the results still owed by the block.
    logic signed [VALUE_W-1:0] held_values[$];
    res_t                      pending_results[$];

    int error_count;
    int items_sent;
    int results_checked;
    int status_seen[4];
    int burst_left;
    int cycle_count;

    max_priority_queue dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .done    (done),
        .result  (result)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: end the run if the block stops answering.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $realtime, pending_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Apply one command to the shadow queue and return the result it must produce.
    // An insert lands above every held value that is less than or equal to it, so
    // among equal values the newest is removed first.
    function automatic res_t step_held_values(input action_t act,
                                              input logic signed [VALUE_W-1:0] val);
        res_t outcome;
        int   pos;
        int   held;
        outcome.out_value = '0;
        if (act == ACT_INSERT)
        begin
            if (held_values.size() >= CAPACITY_DEF)
            begin
                outcome.status = ST_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < held_values.size() && held_values[pos] <= val)
                    pos++;
                held_values.insert(pos, val);
                outcome.status = ST_INSERTED;
            end
        end
        else
        begin
            if (held_values.size() == 0)
            begin
                outcome.status = ST_UNDERFLOW;
            end
            else
            begin
                outcome.out_value = held_values.pop_back();
                outcome.status    = ST_REMOVED;
            end
        end
        held = held_values.size();
        outcome.occupancy = held[OCC_W-1:0];
        return outcome;
    endfunction

    // Values cluster on the extremes and on a narrow band around zero so that
    // ties and sign boundaries come up often; the rest are full 32-bit random.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3:    return int'($urandom_range(0, 6)) - 3;
            default: return $urandom;
        endcase
    endfunction

    // Check every strobed result against the oldest outstanding expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got value %0d status %0d occ %0d",
                         $realtime, result.out_value, result.status, result.occupancy);
                error_count++;
            end
            else
            begin
                if (result.out_value !== pending_results[0].out_value)
                begin
                    $display("%0t: out_value mismatch, expected %0d, got %0d",
                             $realtime, pending_results[0].out_value, result.out_value);
                    error_count++;
                end
                if (result.status !== pending_results[0].status)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $realtime, pending_results[0].status, result.status);
                    error_count++;
                end
                if (result.occupancy !== pending_results[0].occupancy)
                begin
                    $display("%0t: occupancy mismatch, expected %0d, got %0d",
                             $realtime, pending_results[0].occupancy, result.occupancy);
                    error_count++;
                end
                status_seen[pending_results[0].status]++;
                void'(pending_results.pop_front());
                results_checked++;
            end
        end
    end

    // Present one command at the falling edge and hold it until the block takes
    // the transfer; start stays high so back-to-back commands need no gap.
    task automatic send_cmd(input action_t act, input logic signed [VALUE_W-1:0] val);
        @(negedge clk);
        start          = 1'b1;
        command.action = act;
        command.value  = val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(step_held_values(act, val));
        items_sent++;
    endtask

    // Drop start for a number of cycles.
    task automatic idle_gap(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    // Send with burst pacing: random burst lengths, random gaps, and now and then
    // a long burst with no idling at all.
    task automatic send_paced(input action_t act, input logic signed [VALUE_W-1:0] val);
        send_cmd(act, val);
        burst_left--;
        if (burst_left <= 0)
        begin
            if ($urandom_range(0, 3) == 0)
                idle_gap(0);
            else
                idle_gap($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
    endtask

    // Stop sending and hold off until every outstanding result has arrived.
    task automatic wait_drained();
        idle_gap(1);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Remove from the empty queue after reset.
    task automatic test_underflow();
        send_cmd(ACT_REMOVE, VAL_MAX);
        wait_drained();
    endtask

    // Most negative, most positive, zero and minus one; drain past empty.
    task automatic test_extremes();
        send_cmd(ACT_INSERT, 32'sd0);
        send_cmd(ACT_INSERT, VAL_MIN);
        send_cmd(ACT_INSERT, VAL_MAX);
        send_cmd(ACT_INSERT, -32'sd1);
        repeat (5)
            send_cmd(ACT_REMOVE, 32'sh5555_AAAA);
        wait_drained();
    endtask

    // Ties: a new value goes above its equals; removal order is checked via
    // the values and occupancy that come back.
    task automatic test_equal_values();
        send_cmd(ACT_INSERT, 32'sd7);
        send_cmd(ACT_INSERT, -32'sd7);
        send_cmd(ACT_INSERT, 32'sd7);
        send_cmd(ACT_REMOVE, 32'sd0);
        send_cmd(ACT_INSERT, -32'sd7);
        send_cmd(ACT_REMOVE, -32'sd1);
        send_cmd(ACT_REMOVE, 32'sd0);
        send_cmd(ACT_REMOVE, 32'sd0);
        wait_drained();
    endtask

    // Fill to capacity, push a few rejected inserts, then drain through underflow.
    task automatic test_fill_drain(input int rounds);
        int extra;
        repeat (rounds)
        begin
            extra = $urandom_range(1, 3);
            repeat (CAPACITY_DEF - held_values.size() + extra)
                send_paced(ACT_INSERT, pick_value());
            extra = $urandom_range(1, 2);
            repeat (held_values.size() + extra)
                send_paced(ACT_REMOVE, $urandom);
        end
        wait_drained();
    endtask

    // Random mix; lean toward removes when nearly full and inserts when nearly
    // empty so that occupancy wanders over the whole range.
    task automatic test_random_mix(input int count);
        int      lean;
        action_t act;
        repeat (count)
        begin
            if (held_values.size() < 4)
                lean = 25;
            else if (held_values.size() > 12)
                lean = 75;
            else
                lean = 50;
            act = ($urandom_range(0, 99) < lean) ? ACT_REMOVE : ACT_INSERT;
            send_paced(act, pick_value());
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        command         = '0;
        error_count     = 0;
        items_sent      = 0;
        results_checked = 0;
        cycle_count     = 0;
        burst_left      = 1;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // Hold reset asserted, then release it on a falling edge.
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_underflow();
        test_extremes();
        test_equal_values();
        test_fill_drain(4);
        test_random_mix(500);

        // Allow a few more cycles for any stray strobe to show up.
        repeat (DRAIN_TAIL)
            @(posedge clk);

        $display("Covered %0d transfers, %0d results checked: %0d inserted, %0d removed,",
                 items_sent, results_checked, status_seen[ST_INSERTED],
                 status_seen[ST_REMOVED]);
        $display("%0d underflows on empty, %0d rejected when full; %0d mismatches.",
                 status_seen[ST_UNDERFLOW], status_seen[ST_FULL], error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
